/* rtl/dtpb_pkg.sv */
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared types and constants of the depth-to-point back-projection block.
// ----------------------------------------------------------------------------
package dtpb_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_Y = 3'd6;

   localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd640;
   localparam logic [15:0] RST_MIN_DEPTH     = 16'd10;
   localparam logic [15:0] RST_MAX_DEPTH     = 16'd5000;
   localparam logic [15:0] RST_CENTER_X      = 16'd5112;
   localparam logic [15:0] RST_CENTER_Y      = 16'd3832;
   localparam logic [23:0] RST_RECIP_FOCAL_X = 24'd31957;
   localparam logic [23:0] RST_RECIP_FOCAL_Y = 24'd31957;

   // Row counter wraps after 4096 rows
   localparam int ROW_W = 12;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   // Fixed-point projection
   localparam int FRAC_BITS   = 28;
   localparam int RECIP_LO_W  = 12;
   localparam logic [23:0] SAT_POS = 24'h7FFFFF;
   localparam logic [23:0] SAT_NEG = 24'h800000;

   typedef struct packed {
      logic [15:0] depth_mm;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } pix_type;

   typedef struct packed {
      logic [12:0] image_width;
      logic [15:0] min_depth_mm;
      logic [15:0] max_depth_mm;
   } range_cfg_type;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [23:0] recip_focal_x;
      logic [23:0] recip_focal_y;
   } cam_cfg_type;

endpackage

/* rtl/dtpb_front.sv */
// ----------------------------------------------------------------------------
// dtpb_front
// Accepts pixels, tracks raster position and keeps sampled in-range pixels.
// ----------------------------------------------------------------------------
module dtpb_front import dtpb_pkg::*; #(
   parameter int MAX_WIDTH     = 4096,
   parameter int SAMPLE_STRIDE = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_frame_start,
   input  pix_type                            req_pix,
   input  range_cfg_type                      cfg,
   input  logic                               queue_full,
   output logic                               push,
   output logic [$clog2(MAX_WIDTH+1)-1:0]     push_col,
   output logic [ROW_W-1:0]                   push_row,
   output pix_type                            push_pix
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int PW = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PW-1:0]    cph_ff, cph_in;
   logic [PW-1:0]    rph_ff, rph_in;

   logic [CW-1:0]    width;
   logic [CW-1:0]    c0, c1, c2;
   logic [ROW_W-1:0] r0, r1;
   logic [PW-1:0]    cp0, cp1, rp0, rp1;
   logic             accept;
   logic             keep;

   function automatic logic [PW-1:0] next_phase(input logic [PW-1:0] p);
      logic [PW:0] s;
      s = {1'b0, p} + 1'b1;
      return (s == (PW+1)'(SAMPLE_STRIDE)) ? '0 : s[PW-1:0];
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      if (cfg.image_width == 13'd0) begin
         width = CW'(1);
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         width = MAX_W;
      end else begin
         width = CW'(cfg.image_width);
      end
   end

   always_comb begin
      c0  = req_frame_start ? '0 : col_ff;
      r0  = req_frame_start ? '0 : row_ff;
      cp0 = req_frame_start ? '0 : cph_ff;
      rp0 = req_frame_start ? '0 : rph_ff;

      // A width that shrank while idle ends the current row first.
      c1  = c0;
      cp1 = cp0;
      r1  = r0;
      rp1 = rp0;
      if (c0 >= width) begin
         c1  = '0;
         cp1 = '0;
         r1  = r0 + 1'b1;
         rp1 = (r1 == '0) ? '0 : next_phase(rp0);
      end

      keep = (cp1 == '0) && (rp1 == '0) &&
             (req_pix.depth_mm >= cfg.min_depth_mm) &&
             (req_pix.depth_mm <= cfg.max_depth_mm);

      c2     = c1 + 1'b1;
      col_in = c2;
      cph_in = next_phase(cp1);
      row_in = r1;
      rph_in = rp1;
      if (c2 >= width) begin
         col_in = '0;
         cph_in = '0;
         row_in = r1 + 1'b1;
         rph_in = (row_in == '0) ? '0 : next_phase(rp1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

   assign push     = accept && keep;
   assign push_col = c1;
   assign push_row = r1;
   assign push_pix = req_pix;

endmodule

/* rtl/dtpb_queue.sv */
// ----------------------------------------------------------------------------
// dtpb_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module dtpb_queue import dtpb_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty,
   output logic              full
);

   logic [DATA_W-1:0] entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/dtpb_back.sv */
// ----------------------------------------------------------------------------
// dtpb_back
// Projection pipeline: offset, two multiplies, rounding and saturation.
// ----------------------------------------------------------------------------
module dtpb_back import dtpb_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cam_cfg_type                    cfg,
   input  logic                           queue_empty,
   output logic                           pop,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] item_col,
   input  logic [ROW_W-1:0]               item_row,
   input  pix_type                        item_pix,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [23:0]             rsp_point_x_mm,
   output logic signed [23:0]             rsp_point_y_mm,
   output logic [15:0]                    rsp_point_z_mm,
   output logic [7:0]                     rsp_out_blue,
   output logic [7:0]                     rsp_out_green,
   output logic [7:0]                     rsp_out_red
);

   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int MW   = (CW + 4 > 16) ? CW + 4 : 16;   // offset magnitude
   localparam int P1W  = MW + 16;                        // times depth
   localparam int PPW  = P1W + RECIP_LO_W;               // partial products
   localparam int SUMW = PPW + RECIP_LO_W + 1;
   localparam int RW   = SUMW - FRAC_BITS;
   localparam logic [SUMW-1:0] ROUND   = SUMW'(1) << (FRAC_BITS - 1);
   localparam logic [RW-1:0]   LIM_POS = RW'(SAT_POS);
   localparam logic [RW-1:0]   LIM_NEG = RW'(SAT_NEG);

   // Lane 0 is x, lane 1 is y.
   logic [MW-1:0]   pos   [2];
   logic [MW-1:0]   ctr   [2];
   logic [23:0]     recip [2];
   logic signed [MW:0] off [2];

   logic            adv;
   logic            va_ff, vb_ff, vc_ff, vd_ff, out_valid_ff;
   pix_type         pa_ff, pb_ff, pc_ff, pd_ff, out_pix_ff;
   logic [1:0]      na_ff, nb_ff, nc_ff, nd_ff;
   logic [1:0]      neg_in;
   logic [MW-1:0]   mag_in [2];
   logic [MW-1:0]   mag_ff [2];
   logic [P1W-1:0]  p1_ff  [2];
   logic [PPW-1:0]  lo_ff  [2];
   logic [PPW-1:0]  hi_ff  [2];
   logic [SUMW-1:0] sum_in [2];
   logic [RW-1:0]   r_ff   [2];
   logic [23:0]     sat_in [2];
   logic [23:0]     point_ff [2];

   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && !queue_empty;

   always_comb begin
      pos[0]   = MW'({item_col, 4'b0000});
      pos[1]   = MW'({item_row, 4'b0000});
      ctr[0]   = MW'(cfg.center_x);
      ctr[1]   = MW'(cfg.center_y);
      recip[0] = cfg.recip_focal_x;
      recip[1] = cfg.recip_focal_y;
      for (int i = 0; i < 2; i++) begin
         off[i]    = $signed({1'b0, pos[i]}) - $signed({1'b0, ctr[i]});
         neg_in[i] = off[i][MW];
         mag_in[i] = neg_in[i] ? MW'(-off[i]) : MW'(off[i]);
         sum_in[i] = SUMW'(lo_ff[i]) + SUMW'({hi_ff[i], RECIP_LO_W'(0)}) + ROUND;
         // Round half away from zero on the magnitude, then clamp.
         if (nd_ff[i]) begin
            sat_in[i] = (r_ff[i] > LIM_NEG) ? SAT_NEG : (~r_ff[i][23:0] + 24'd1);
         end else begin
            sat_in[i] = (r_ff[i] > LIM_POS) ? SAT_POS : r_ff[i][23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff        <= !queue_empty;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         out_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff      <= item_pix;
         pb_ff      <= pa_ff;
         pc_ff      <= pb_ff;
         pd_ff      <= pc_ff;
         out_pix_ff <= pd_ff;
         na_ff      <= neg_in;
         nb_ff      <= na_ff;
         nc_ff      <= nb_ff;
         nd_ff      <= nc_ff;
         for (int i = 0; i < 2; i++) begin
            mag_ff[i]   <= mag_in[i];
            p1_ff[i]    <= P1W'(mag_ff[i]) * P1W'(pa_ff.depth_mm);
            lo_ff[i]    <= PPW'(p1_ff[i]) * PPW'(recip[i][RECIP_LO_W-1:0]);
            hi_ff[i]    <= PPW'(p1_ff[i]) * PPW'(recip[i][23:RECIP_LO_W]);
            r_ff[i]     <= sum_in[i][SUMW-1:FRAC_BITS];
            point_ff[i] <= sat_in[i];
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x_mm = point_ff[0];
   assign rsp_point_y_mm = point_ff[1];
   assign rsp_point_z_mm = out_pix_ff.depth_mm;
   assign rsp_out_blue   = out_pix_ff.blue;
   assign rsp_out_green  = out_pix_ff.green;
   assign rsp_out_red    = out_pix_ff.red;

endmodule

/* rtl/depth_to_point_backprojection.sv */
// ----------------------------------------------------------------------------
// depth_to_point_backprojection
// Turns a raster stream of depth and color pixels into sampled 3D points.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle in raster order while req_stall is low;
// req_frame_start marks the first pixel of a frame. Every SAMPLE_STRIDE-th
// pixel of every SAMPLE_STRIDE-th row whose depth lies within the configured
// range yields a point in millimetres with its color; all other pixels are
// consumed and give nothing. A front stage tracks position and filters, a
// four-item queue decouples it from a five-stage projection pipeline (offset,
// depth product, reciprocal partial products, rounding, saturation), and the
// sustained rate is one pixel per cycle when nothing stalls. Registers are to
// be written by the user only while no item is in flight; the block itself
// does not enforce this.
module depth_to_point_backprojection import dtpb_pkg::*; #(
   parameter int MAX_WIDTH     = 4096,
   parameter int SAMPLE_STRIDE = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_depth_mm,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_red,
   input  logic                   req_frame_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [23:0]     rsp_point_x_mm,
   output logic signed [23:0]     rsp_point_y_mm,
   output logic [15:0]            rsp_point_z_mm,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_red
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int QW = CW + ROW_W + $bits(pix_type);

   range_cfg_type    range_cfg_ff;
   cam_cfg_type      cam_cfg_ff;
   pix_type          req_pix;
   logic             push, pop, q_empty, q_full;
   logic [CW-1:0]    push_col, pop_col;
   logic [ROW_W-1:0] push_row, pop_row;
   pix_type          push_pix, pop_pix;
   logic [QW-1:0]    q_push_data, q_pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_cfg_ff.image_width  <= RST_IMAGE_WIDTH;
         range_cfg_ff.min_depth_mm <= RST_MIN_DEPTH;
         range_cfg_ff.max_depth_mm <= RST_MAX_DEPTH;
         cam_cfg_ff.center_x       <= RST_CENTER_X;
         cam_cfg_ff.center_y       <= RST_CENTER_Y;
         cam_cfg_ff.recip_focal_x  <= RST_RECIP_FOCAL_X;
         cam_cfg_ff.recip_focal_y  <= RST_RECIP_FOCAL_Y;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   range_cfg_ff.image_width  <= csr_wdata[12:0];
            CSR_MIN_DEPTH:     range_cfg_ff.min_depth_mm <= csr_wdata[15:0];
            CSR_MAX_DEPTH:     range_cfg_ff.max_depth_mm <= csr_wdata[15:0];
            CSR_CENTER_X:      cam_cfg_ff.center_x       <= csr_wdata[15:0];
            CSR_CENTER_Y:      cam_cfg_ff.center_y       <= csr_wdata[15:0];
            CSR_RECIP_FOCAL_X: cam_cfg_ff.recip_focal_x  <= csr_wdata;
            CSR_RECIP_FOCAL_Y: cam_cfg_ff.recip_focal_y  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_pix.depth_mm = req_depth_mm;
   assign req_pix.blue     = req_blue;
   assign req_pix.green    = req_green;
   assign req_pix.red      = req_red;

   dtpb_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .SAMPLE_STRIDE (SAMPLE_STRIDE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .req_pix         (req_pix),
      .cfg             (range_cfg_ff),
      .queue_full      (q_full),
      .push            (push),
      .push_col        (push_col),
      .push_row        (push_row),
      .push_pix        (push_pix)
   );

   assign q_push_data = {push_col, push_row, push_pix};
   assign {pop_col, pop_row, pop_pix} = q_pop_data;

   dtpb_queue #(
      .DATA_W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_push_data),
      .pop       (pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   dtpb_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cam_cfg_ff),
      .queue_empty    (q_empty),
      .pop            (pop),
      .item_col       (pop_col),
      .item_row       (pop_row),
      .item_pix       (pop_pix),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x_mm (rsp_point_x_mm),
      .rsp_point_y_mm (rsp_point_y_mm),
      .rsp_point_z_mm (rsp_point_z_mm),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red)
   );

endmodule

/* rtl/dtpb_checker.sv */
// ----------------------------------------------------------------------------
// dtpb_checker
// Port-level checks of the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
module dtpb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic signed [23:0]    rsp_point_x_mm,
   input logic signed [23:0]    rsp_point_y_mm,
   input logic [15:0]           rsp_point_z_mm,
   input logic [7:0]            rsp_out_blue,
   input logic [7:0]            rsp_out_green,
   input logic [7:0]            rsp_out_red
);

   // A stalled result item stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x_mm) &&
         $stable(rsp_point_y_mm) && $stable(rsp_point_z_mm) &&
         $stable(rsp_out_blue) && $stable(rsp_out_green) && $stable(rsp_out_red))
      else $error("result item changed while stalled");

   // Right after reset nothing is in flight and the queue is empty.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result item shown right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("input stalled right after reset");

   // The pipeline is at least five deep: no item taken in the last cycle
   // can appear as a result unless something else was already in flight.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |=> !rsp_valid)
      else $error("result item appeared too early after reset");

endmodule

bind depth_to_point_backprojection dtpb_checker u_dtpb_checker (.*);
